### rtl/abc_pkg.sv
// ----------------------------------------------------------------------------
// abc_pkg: shared definitions for the articulation point and bridge counter
// Default sizes, field widths, item kinds and the controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package abc_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int MAX_EDGES_DEF    = 1024;

    localparam int CNT_W   = 9;   // vertex count register and endpoint fields
    localparam int BRG_W   = 8;   // bridge count field
    localparam int IN_TDW  = 24;  // two endpoints, padded to whole bytes
    localparam int OUT_TDW = 24;  // counts and drop flag, padded to whole bytes

    localparam logic [CNT_W-1:0] VCOUNT_RESET = 9'd256;
    localparam logic [1:0]       ROOT_CHILD_LIMIT = 2'd2;
    localparam logic [BRG_W-1:0] BRIDGE_MAX = 8'd255;

    typedef enum logic {
        KIND_ADD = 1'b0,
        KIND_RUN = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_A,
        S_ADD_RB,
        S_ADD_B,
        S_SCAN,
        S_SCAN_CHK,
        S_EDGE,
        S_SLOT,
        S_NBR,
        S_POP,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

### rtl/abc_ram.sv
// ----------------------------------------------------------------------------
// abc_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module abc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/articulation_bridge_counter.sv
// Add item: read head, link first slot, read head, link second slot.
// Run item: scans the roots, starts a walk from each unvisited one, reads every
// adjacency slot and retires every tree edge. Afterwards a clearing pass
// empties the vertex memory; the same pass runs after reset. No input transfer
// is taken during either.
// ----------------------------------------------------------------------------
// articulation_bridge_counter: counts articulation points and bridges
// Stores edges in linked adjacency lists and walks the graph depth first
// with an explicit stack memory, keeping discovery times and low values.
// ----------------------------------------------------------------------------
`default_nettype none

module articulation_bridge_counter
    import abc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CNT_W-1:0]   i_cfg_wdata,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [IN_TDW-1:0]  i_s_axis_tdata,   // endpoint_a, endpoint_b
    input  wire logic               i_s_axis_tuser,   // kind
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [OUT_TDW-1:0]      o_m_axis_tdata    // articulation_count,
                                                      // bridge_count, edges_dropped
);

    localparam int SLOTS = 2 * MAX_EDGES;
    localparam int VW    = $clog2(MAX_VERTICES + 1);
    localparam int SW    = $clog2(SLOTS + 1);
    localparam int SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int STW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [SW-1:0] EMPTY = SW'(SLOTS);

    typedef struct packed {
        logic [SW-1:0] head;
        logic [VW-1:0] visit;
    } t_vrec;

    typedef struct packed {
        logic [SW-1:0] next;
        logic [VW-1:0] target;
    } t_slot;

    typedef struct packed {
        logic [VW-1:0] v;
        logic [SW-1:0] slot;
        logic [1:0]    ch;
        logic [VW-1:0] disc;
        logic [VW-1:0] low;
        logic [VW-1:0] par;
        logic          cut;
    } t_frame;

    t_state r_state, n_state;

    logic [CNT_W-1:0] r_vcount;
    logic [VW-1:0]    r_sweep;
    logic [VW-1:0]    r_a, r_b, r_w;
    logic [SW-1:0]    r_slots;
    logic             r_ovf;
    logic [VW-1:0]    r_time;
    logic [BRG_W-1:0] r_bridges;
    logic [VW-1:0]    r_cuts;
    logic [STW-1:0]   r_sp;
    logic [VW:0]      r_root;
    logic [VW-1:0]    r_v, r_disc, r_low, r_par;
    logic [SW-1:0]    r_slot;
    logic [1:0]       r_ch;
    logic             r_cut;
    logic             r_ovalid;
    logic [CNT_W-1:0] r_oart;
    logic [BRG_W-1:0] r_obrg;
    logic             r_odrop;

    logic [VW-1:0]    act;
    logic [CNT_W-1:0] in_a, in_b;
    logic             s_acc, ends_ok, full;
    logic [VW-1:0]    nxt_time;
    logic [1:0]       ch_inc;
    t_frame           push_f, pop_f;
    t_frame           st_rd;
    logic             pop_cut;

    logic              v_we;
    logic [VW-1:0]     v_waddr, v_raddr;
    t_vrec             v_wdata, v_rd;
    logic              sl_we;
    logic [SAW-1:0]    sl_waddr, sl_raddr;
    t_slot             sl_wdata, sl_rd;
    logic              st_we;
    logic [STW-1:0]    st_waddr, st_raddr;

    abc_ram #(.WIDTH($bits(t_vrec)), .DEPTH(MAX_VERTICES + 1)) u_vram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rd)
    );

    abc_ram #(.WIDTH($bits(t_slot)), .DEPTH(SLOTS)) u_sram (
        .i_clk(i_clk), .i_we(sl_we), .i_waddr(sl_waddr), .i_wdata(sl_wdata),
        .i_raddr(sl_raddr), .o_rdata(sl_rd)
    );

    abc_ram #(.WIDTH($bits(t_frame)), .DEPTH(MAX_VERTICES)) u_stack (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(push_f),
        .i_raddr(st_raddr), .o_rdata(st_rd)
    );

    assign in_a = i_s_axis_tdata[CNT_W-1:0];
    assign in_b = i_s_axis_tdata[2*CNT_W-1:CNT_W];
    assign act  = (32'(r_vcount) > MAX_VERTICES) ? VW'(MAX_VERTICES) : VW'(r_vcount);
    assign s_acc = i_s_axis_tvalid && o_s_axis_tready;
    assign ends_ok = (in_a != '0) && (in_b != '0)
                     && (32'(in_a) <= 32'(act)) && (32'(in_b) <= 32'(act));
    assign full = (32'(r_slots) + 32'd2) > SLOTS;
    assign nxt_time = r_time + VW'(1);
    assign ch_inc = (r_ch >= ROOT_CHILD_LIMIT) ? r_ch : r_ch + 2'd1;

    always_comb begin
        push_f = '{v: r_v, slot: r_slot, ch: ch_inc, disc: r_disc, low: r_low,
                   par: r_par, cut: r_cut};
        pop_f = st_rd;
        pop_cut = st_rd.cut
                  || (st_rd.par == st_rd.v && st_rd.ch >= ROOT_CHILD_LIMIT)
                  || (st_rd.par != st_rd.v && r_low >= st_rd.disc);
        if (r_low < st_rd.low) begin
            pop_f.low = r_low;
        end
        pop_f.cut = pop_cut;
    end

    always_comb begin
        n_state = r_state;
        o_s_axis_tready = 1'b0;
        v_we = 1'b0;
        v_waddr = r_sweep;
        v_wdata = '{head: EMPTY, visit: '0};
        v_raddr = VW'(in_a);
        sl_we = 1'b0;
        sl_waddr = r_slots[SAW-1:0];
        sl_wdata = '{next: v_rd.head, target: r_b};
        sl_raddr = r_slot[SAW-1:0];
        st_we = 1'b0;
        st_waddr = r_sp;
        st_raddr = r_sp - STW'(1);
        unique case (r_state)
            S_CLEAR: begin
                v_we = 1'b1;
                if (r_sweep == VW'(MAX_VERTICES)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (s_acc) begin
                    if (i_s_axis_tuser == KIND_RUN) begin
                        n_state = S_SCAN;
                    end else if (ends_ok && !full) begin
                        n_state = S_ADD_A;
                    end
                end
            end
            S_ADD_A: begin
                v_we = 1'b1;
                v_waddr = r_a;
                v_wdata = '{head: r_slots, visit: '0};
                sl_we = 1'b1;
                n_state = S_ADD_RB;
            end
            S_ADD_RB: begin
                v_raddr = r_b;
                n_state = S_ADD_B;
            end
            S_ADD_B: begin
                v_we = 1'b1;
                v_waddr = r_b;
                v_wdata = '{head: r_slots, visit: '0};
                sl_we = 1'b1;
                sl_wdata = '{next: v_rd.head, target: r_a};
                n_state = S_IDLE;
            end
            S_SCAN: begin
                v_raddr = r_root[VW-1:0];
                if (r_root > {1'b0, act}) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                v_waddr = r_root[VW-1:0];
                v_wdata = '{head: v_rd.head, visit: nxt_time};
                if (v_rd.visit == '0) begin
                    v_we = 1'b1;
                    n_state = S_EDGE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_EDGE: begin
                if (r_slot == EMPTY) begin
                    n_state = (r_sp == '0) ? S_SCAN : S_POP;
                end else begin
                    n_state = S_SLOT;
                end
            end
            S_SLOT: begin
                v_raddr = sl_rd.target;
                if (sl_rd.target == '0 || sl_rd.target > act) begin
                    n_state = S_EDGE;
                end else begin
                    n_state = S_NBR;
                end
            end
            S_NBR: begin
                v_waddr = r_w;
                v_wdata = '{head: v_rd.head, visit: nxt_time};
                if (v_rd.visit == '0) begin
                    v_we = 1'b1;
                    st_we = 1'b1;
                end
                n_state = S_EDGE;
            end
            S_POP: begin
                n_state = S_EDGE;
            end
            S_EMIT: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_state = S_CLEAR;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount  <= VCOUNT_RESET;
            r_sweep   <= '0;
            r_slots   <= '0;
            r_ovf     <= 1'b0;
            r_time    <= '0;
            r_bridges <= '0;
            r_cuts    <= '0;
            r_sp      <= '0;
            r_root    <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_vcount <= i_cfg_wdata;
            end
            if (r_state == S_EMIT && (!r_ovalid || i_m_axis_tready)) begin
                r_ovalid <= 1'b1;
                r_oart   <= CNT_W'(r_cuts);
                r_obrg   <= r_bridges;
                r_odrop  <= r_ovf;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    if (r_sweep == VW'(MAX_VERTICES)) begin
                        r_sweep   <= '0;
                        r_slots   <= '0;
                        r_ovf     <= 1'b0;
                        r_time    <= '0;
                        r_bridges <= '0;
                        r_cuts    <= '0;
                        r_sp      <= '0;
                    end else begin
                        r_sweep <= r_sweep + VW'(1);
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_a <= VW'(in_a);
                        r_b <= VW'(in_b);
                        r_root <= (VW + 1)'(1);
                        if (i_s_axis_tuser == KIND_ADD && ends_ok && full) begin
                            r_ovf <= 1'b1;
                        end
                    end
                end
                S_ADD_A, S_ADD_B: begin
                    r_slots <= r_slots + SW'(1);
                end
                S_SCAN_CHK: begin
                    if (v_rd.visit == '0) begin
                        r_time <= nxt_time;
                        r_v    <= r_root[VW-1:0];
                        r_slot <= v_rd.head;
                        r_ch   <= '0;
                        r_disc <= nxt_time;
                        r_low  <= nxt_time;
                        r_par  <= r_root[VW-1:0];
                        r_cut  <= 1'b0;
                        r_sp   <= '0;
                    end else begin
                        r_root <= r_root + (VW + 1)'(1);
                    end
                end
                S_EDGE: begin
                    if (r_slot == EMPTY) begin
                        if (r_sp == '0) begin
                            r_root <= r_root + (VW + 1)'(1);
                        end else begin
                            r_sp <= r_sp - STW'(1);
                        end
                    end
                end
                S_SLOT: begin
                    r_slot <= sl_rd.next;
                    r_w    <= sl_rd.target;
                end
                S_NBR: begin
                    if (v_rd.visit == '0) begin
                        // Tree edge: the current frame goes to the stack, the child
                        // becomes the top frame.
                        r_sp   <= r_sp + STW'(1);
                        r_time <= nxt_time;
                        r_v    <= r_w;
                        r_slot <= v_rd.head;
                        r_ch   <= '0;
                        r_disc <= nxt_time;
                        r_low  <= nxt_time;
                        r_par  <= r_v;
                        r_cut  <= 1'b0;
                    end else if (r_par != r_w && v_rd.visit < r_low) begin
                        r_low <= v_rd.visit;
                    end
                end
                S_POP: begin
                    // Retire the child in r_v into its parent from the stack.
                    if (st_rd.disc < r_low && r_bridges != BRIDGE_MAX) begin
                        r_bridges <= r_bridges + BRG_W'(1);
                    end
                    if (pop_cut && !st_rd.cut) begin
                        r_cuts <= r_cuts + VW'(1);
                    end
                    r_v    <= pop_f.v;
                    r_slot <= pop_f.slot;
                    r_ch   <= pop_f.ch;
                    r_disc <= pop_f.disc;
                    r_low  <= pop_f.low;
                    r_par  <= pop_f.par;
                    r_cut  <= pop_f.cut;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {(OUT_TDW - CNT_W - BRG_W - 1)'(0), r_odrop, r_obrg, r_oart};

endmodule

`default_nettype wire

### test/articulation_bridge_counter_test.sv
// ----------------------------------------------------------------------------
// articulation_bridge_counter_test: self-checking bench for the bridge counter
// Loads graphs edge by edge, runs the analysis and compares every count with
// fixed expectations (directed rows) or a local depth-first predictor, mostly under random idling on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module articulation_bridge_counter_test;
    import abc_pkg::*;

    localparam int NV        = 256;
    localparam int NSLOT     = 2048;
    localparam int SETTLE    = 300;       // covers the clearing pass after a run
    localparam int LIMIT     = 3000000;
    localparam int RAND_ITEMS = 1800;

    typedef struct packed {
        logic [CNT_W-1:0] cuts;
        logic [BRG_W-1:0] bridges;
        logic             dropped;
    } t_counts;

    typedef struct {
        t_kind            kind;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
        bit               typed;
        t_counts          want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [CNT_W-1:0]   cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [IN_TDW-1:0]  s_data = '0;     // endpoint_a, endpoint_b
    logic               s_user = 1'b0;   // kind
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [OUT_TDW-1:0] m_data;          // articulation_count, bridge_count, edges_dropped

    articulation_bridge_counter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: adjacency lists, walk state and the vertex count register.
    int      vcount;
    int      head[0:NV];
    int      nxt[0:NSLOT-1];
    int      tgt[0:NSLOT-1];
    int      used, overflow, clock_no, bridge_sum, depth;
    int      disc[0:NV];
    int      lowv[0:NV];
    int      parent[0:NV];
    bit      is_cut[0:NV];
    int      fr_v[0:NV];
    int      fr_slot[0:NV];
    int      fr_kids[0:NV];

    t_counts pending[$];
    int      errors = 0, cycles = 0, items_sent = 0, graphs = 0, drops_seen = 0;
    int      src_idle = 0, snk_idle = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    function automatic int active_n();
        return vcount > NV ? NV : vcount;
    endfunction

    function automatic void clear_graph();
        for (int v = 0; v <= NV; v++) begin
            head[v] = NSLOT; disc[v] = 0; lowv[v] = 0; parent[v] = v; is_cut[v] = 0;
        end
        used = 0; overflow = 0; clock_no = 0; bridge_sum = 0;
    endfunction

    function automatic void link(input int from, input int to);
        tgt[used] = to;
        nxt[used] = head[from];
        head[from] = used;
        used++;
    endfunction

    function automatic void discover(input int v);
        clock_no++;
        disc[v] = clock_no;
        lowv[v] = clock_no;
        if (depth <= NV) begin
            fr_v[depth] = v; fr_slot[depth] = head[v]; fr_kids[depth] = 0;
            depth++;
        end
    endfunction

    function automatic void walk(input int root, input int n);
        int v, w, u, t;
        depth = 0;
        discover(root);
        while (depth > 0) begin
            t = depth - 1;
            v = fr_v[t];
            if (fr_slot[t] < NSLOT) begin
                w = tgt[fr_slot[t]];
                fr_slot[t] = nxt[fr_slot[t]];
                if (w == 0 || w > n) continue;
                if (disc[w] == 0) begin
                    fr_kids[t]++;
                    parent[w] = v;
                    discover(w);
                end else if (parent[v] != w && disc[w] < lowv[v]) begin
                    lowv[v] = disc[w];
                end
            end else begin
                depth--;
                if (depth > 0) begin
                    t = depth - 1;
                    u = fr_v[t];
                    if (lowv[v] < lowv[u]) lowv[u] = lowv[v];
                    if (disc[u] < lowv[v] && bridge_sum < 255) bridge_sum++;
                    if (parent[u] == u && fr_kids[t] >= ROOT_CHILD_LIMIT) is_cut[u] = 1;
                    if (parent[u] != u && lowv[v] >= disc[u]) is_cut[u] = 1;
                end
            end
        end
    endfunction

    // Returns 1 with the counts when the item is a run.
    function automatic bit predict_counts(input t_kind kind, input int a, input int b,
                                          output t_counts res);
        int n, cuts;
        n = active_n();
        res = '0;
        if (kind == KIND_ADD) begin
            if (a == 0 || b == 0 || a > n || b > n) return 0;
            if (used + 2 > NSLOT) begin
                overflow = 1;
                return 0;
            end
            link(a, b);
            link(b, a);
            return 0;
        end
        for (int v = 1; v <= n; v++)
            if (disc[v] == 0) walk(v, n);
        cuts = 0;
        for (int v = 1; v <= NV; v++) cuts += is_cut[v];
        res.cuts = cuts[CNT_W-1:0];
        res.bridges = bridge_sum[BRG_W-1:0];
        res.dropped = overflow[0];
        clear_graph();
        return 1;
    endfunction

    always @(negedge i_clk) m_ready <= ($urandom_range(99) >= snk_idle);

    always @(posedge i_clk) begin
        t_counts got, want;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        if (i_rst_n && m_valid && m_ready) begin
            got = t_counts'({m_data[BRG_W+CNT_W], m_data[BRG_W+CNT_W-1:CNT_W],
                             m_data[CNT_W-1:0]});
            got.cuts = m_data[CNT_W-1:0];
            got.bridges = m_data[BRG_W+CNT_W-1:CNT_W];
            got.dropped = m_data[BRG_W+CNT_W];
            if (pending.size() == 0) begin
                report("unexpected result transfer", 1, 0);
            end else begin
                want = pending.pop_front();
                if (got.cuts != want.cuts) report("articulation_count", got.cuts, want.cuts);
                if (got.bridges != want.bridges)
                    report("bridge_count", got.bridges, want.bridges);
                if (got.dropped != want.dropped)
                    report("edges_dropped", got.dropped, want.dropped);
                drops_seen += got.dropped;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(input t_kind kind, input int a, input int b,
                        input bit typed, input t_counts typed_want);
        t_counts res;
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= kind;
        s_data <= {6'd0, b[CNT_W-1:0], a[CNT_W-1:0]};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        items_sent++;
        if (predict_counts(kind, a, b, res)) begin
            pending.insert(pending.size(), typed ? typed_want : res);
            graphs++;
        end
        @(negedge i_clk);
    endtask

    task automatic load_edge(input int a, input int b);
        send(KIND_ADD, a, b, 0, '0);
    endtask

    // The sender holds off until all counts are back and the clearing pass is over.
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge i_clk);
        while (pending.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_vcount(input int value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= value[CNT_W-1:0];
        vcount = value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic int pick_vertex(input int n);
        if ($urandom_range(99) < 4) return $urandom_range(511);
        return $urandom_range(n > 0 ? n : 1, 1);
    endfunction

    t_row rows[] = '{
        '{KIND_RUN, 0, 0, 1, '{9'd0, 8'd0, 1'b0}},
        // Path 1-2-3: middle vertex cut, both edges bridges.
        '{KIND_ADD, 1, 2, 0, '0}, '{KIND_ADD, 2, 3, 0, '0},
        '{KIND_RUN, 0, 0, 1, '{9'd1, 8'd2, 1'b0}},
        // Triangle: no cut vertex, no bridge.
        '{KIND_ADD, 1, 2, 0, '0}, '{KIND_ADD, 2, 3, 0, '0}, '{KIND_ADD, 3, 1, 0, '0},
        '{KIND_RUN, 0, 0, 1, '{9'd0, 8'd0, 1'b0}},
        // A doubled edge still counts as a bridge, since the way back is ignored.
        '{KIND_ADD, 1, 2, 0, '0}, '{KIND_ADD, 2, 1, 0, '0},
        '{KIND_RUN, 0, 0, 1, '{9'd0, 8'd1, 1'b0}},
        // Self loop, top vertex, and endpoints of zero or out of range.
        '{KIND_ADD, 5, 5, 0, '0}, '{KIND_ADD, 256, 1, 0, '0},
        '{KIND_ADD, 0, 3, 0, '0}, '{KIND_ADD, 511, 2, 0, '0},
        '{KIND_RUN, 0, 0, 1, '{9'd0, 8'd1, 1'b0}},
        // Star around a root with two children.
        '{KIND_ADD, 1, 2, 0, '0}, '{KIND_ADD, 1, 3, 0, '0},
        '{KIND_RUN, 0, 0, 1, '{9'd1, 8'd2, 1'b0}}
    };

    initial begin
        int n, edges;
        t_counts unused;
        vcount = VCOUNT_RESET;
        clear_graph();
        src_idle = 14;
        snk_idle = 52;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(negedge i_clk);

        foreach (rows[i]) send(rows[i].kind, rows[i].a, rows[i].b, rows[i].typed, rows[i].want);

        // Overflow: one large graph past the store capacity, at full count.
        set_vcount(256);
        for (int i = 0; i < 1030; i++)
            load_edge($urandom_range(256, 1), $urandom_range(256, 1));
        send(KIND_RUN, 0, 0, 0, unused);

        while (items_sent < RAND_ITEMS) begin
            if (items_sent < 1450) begin
                src_idle = 52; snk_idle = 14;
            end else begin
                src_idle = 0; snk_idle = 0;
            end
            case ($urandom_range(9))
                0: set_vcount(0);
                1: set_vcount($urandom_range(511, 257));
                2: set_vcount(1);
                3: set_vcount(256);
                default: set_vcount($urandom_range(24, 2));
            endcase
            n = active_n();
            edges = $urandom_range(n < 16 ? 3 * n + 2 : 40);
            for (int i = 0; i < edges; i++) begin
                // Half the graphs grow as trees first so cut vertices show up.
                if (i < n - 1 && graphs % 2 == 0)
                    load_edge(i + 2, $urandom_range(i + 1, 1));
                else
                    load_edge(pick_vertex(n), pick_vertex(n));
            end
            if ($urandom_range(7) == 0) set_vcount($urandom_range(n > 1 ? n - 1 : 1, 0));
            send(KIND_RUN, $urandom_range(511), $urandom_range(511), 0, unused);
        end

        drain();
        $display("%0d items sent, %0d graphs analyzed, %0d runs reported dropped edges",
                 items_sent, graphs, drops_seen);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
